// ===== rtl/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// TEA block cipher package
// Shared constants, register codes, pipeline types and the round mix function.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam logic [31:0] TEA_DELTA    = 32'h9e3779b9;
    localparam int          ROUNDS_W     = 7;
    localparam logic [6:0]  ROUNDS_RESET = 7'd32;
    localparam int          ADDR_W       = 5;
    localparam int          DATA_W       = 32;

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_ROUNDS = 3'd4
    } tea_reg_t;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } tea_key_t;

    typedef struct packed {
        logic                dec;
        logic [ROUNDS_W-1:0] n;
        logic [31:0]         sum;
        logic [31:0]         v0;
        logic [31:0]         v1;
    } tea_item_t;

    function automatic logic [31:0] tea_mix(
        input logic [31:0] x,
        input logic [31:0] s,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

endpackage

// ===== rtl/tea_stage.sv =====
// ----------------------------------------------------------------------------
// TEA half-cycle stage
// One register stage that applies one half of a TEA cycle to a request.
// ----------------------------------------------------------------------------
module tea_stage
    import tea_pkg::*;
#(
    parameter int ROUND_IDX   = 0,
    parameter bit SECOND_HALF = 1'b0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  tea_item_t in_item,
    input  tea_key_t  key,
    output logic      out_valid,
    output tea_item_t out_item
);

    logic      valid_reg;
    tea_item_t item_reg;
    tea_item_t item_next;
    logic      active;

    always_comb
    begin
        item_next = in_item;
        active    = in_item.n > ROUNDS_W'(ROUND_IDX);
        if (active)
        begin
            if (!SECOND_HALF)
            begin
                if (in_item.dec)
                begin
                    item_next.v1 = in_item.v1 - tea_mix(in_item.v0, in_item.sum, key.k2, key.k3);
                end
                else
                begin
                    item_next.v0 = in_item.v0 + tea_mix(in_item.v1, in_item.sum, key.k0, key.k1);
                end
            end
            else
            begin
                // The carried sum always holds the value used by the current cycle.
                if (in_item.dec)
                begin
                    item_next.v0  = in_item.v0 - tea_mix(in_item.v1, in_item.sum, key.k0, key.k1);
                    item_next.sum = in_item.sum - TEA_DELTA;
                end
                else
                begin
                    item_next.v1  = in_item.v1 + tea_mix(in_item.v0, in_item.sum, key.k2, key.k3);
                    item_next.sum = in_item.sum + TEA_DELTA;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/tea_obuf.sv =====
// ----------------------------------------------------------------------------
// TEA output buffer
// Output register with a skid entry, so the pipeline stops on a registered
// signal rather than on the downstream ready.
// ----------------------------------------------------------------------------
module tea_obuf
    import tea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    input  logic [31:0] push_first,
    input  logic [31:0] push_second,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_first,
    output logic [31:0] out_second
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic [31:0] out_first_reg;
    logic [31:0] out_second_reg;
    logic [31:0] skid_first_reg;
    logic [31:0] skid_second_reg;
    logic        take;
    logic        push;

    assign room = !skid_valid_reg;
    assign take = out_valid_reg && out_ready;
    assign push = push_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_first_reg  <= skid_first_reg;
                out_second_reg <= skid_second_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_first_reg  <= push_first;
                skid_second_reg <= push_second;
            end
            else
            begin
                out_first_reg  <= push_first;
                out_second_reg <= push_second;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;

endmodule

// ===== rtl/tea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// TEA block cipher
// Pipelined TEA encryption and decryption of 64-bit blocks under a 128-bit key.
// ----------------------------------------------------------------------------
// The block takes one 64-bit request per clock while in_ready is high and returns
// one result per request, in order. With the output not stalled, a result
// passes the input register, the stage registers and the output register in
// turn and is then offered at the output. Each TEA cycle is split over two
// pipeline stages, one per half, so the pipeline is 2*MAX_ROUNDS stages deep
// behind an input register, and a request for fewer rounds simply passes
// through the unused stages. A stalled output fills a skid entry, after which
// in_ready falls. Key and rounds registers must only be written while no
// request is in flight.
module tea_block_cipher
    import tea_pkg::*;
#(
    parameter int MAX_ROUNDS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [31:0]       in_first,
    input  logic [31:0]       in_second,
    input  logic              bypass,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_first,
    output logic [31:0]       out_second
);

    localparam int NSTAGE = 2 * MAX_ROUNDS;

    tea_key_t            key_reg;
    logic [ROUNDS_W-1:0] rounds_reg;
    tea_reg_t            reg_sel;
    logic                wr_en;

    logic                en;
    logic [ROUNDS_W-1:0] n_sat;
    logic [ROUNDS_W-1:0] n_sel;
    tea_item_t           entry_next;
    logic                entry_valid_reg;
    tea_item_t           entry_item_reg;

    logic                stage_valid [0:NSTAGE];
    tea_item_t           stage_item  [0:NSTAGE];

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_sel = tea_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= ROUNDS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_KEY0:   key_reg.k0 <= pwdata;
                REG_KEY1:   key_reg.k1 <= pwdata;
                REG_KEY2:   key_reg.k2 <= pwdata;
                REG_KEY3:   key_reg.k3 <= pwdata;
                REG_ROUNDS: rounds_reg <= pwdata[ROUNDS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_KEY0:   prdata = key_reg.k0;
            REG_KEY1:   prdata = key_reg.k1;
            REG_KEY2:   prdata = key_reg.k2;
            REG_KEY3:   prdata = key_reg.k3;
            REG_ROUNDS: prdata = DATA_W'(rounds_reg);
            default:    prdata = '0;
        endcase
    end

    // Input register: a bypassed block runs with a count of zero.
    assign in_ready = en;
    assign n_sat    = (rounds_reg > ROUNDS_W'(MAX_ROUNDS)) ? ROUNDS_W'(MAX_ROUNDS) : rounds_reg;
    assign n_sel    = bypass ? '0 : n_sat;

    always_comb
    begin
        entry_next.dec = command;
        entry_next.n   = n_sel;
        entry_next.v0  = in_first;
        entry_next.v1  = in_second;
        entry_next.sum = command ? (TEA_DELTA * 32'(n_sel)) : TEA_DELTA;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            entry_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_item_reg <= entry_next;
        end
    end

    assign stage_valid[0] = entry_valid_reg;
    assign stage_item[0]  = entry_item_reg;

    for (genvar j = 0; j < NSTAGE; j++)
    begin : g_stage
        tea_stage #(
            .ROUND_IDX   (j / 2),
            .SECOND_HALF (1'(j % 2))
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[j]),
            .in_item   (stage_item[j]),
            .key       (key_reg),
            .out_valid (stage_valid[j+1]),
            .out_item  (stage_item[j+1])
        );
    end

    tea_obuf u_obuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (stage_valid[NSTAGE]),
        .push_first  (stage_item[NSTAGE].v0),
        .push_second (stage_item[NSTAGE].v1),
        .room        (en),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_first   (out_first),
        .out_second  (out_second)
    );

endmodule

// ===== rtl/tea_checker.sv =====
// ----------------------------------------------------------------------------
// TEA block cipher checker
// Port-level assertions on the cipher, bound to the top level.
// ----------------------------------------------------------------------------
module tea_checker
    import tea_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] prdata,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [31:0]       out_first,
    input logic [31:0]       out_second
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_first) && $stable(out_second))
        else $error("result changed while stalled");

    // Input back-pressure only arises from a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // Taking the waiting result frees the skid entry at once.
    a_stall_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_ready |=> in_ready)
        else $error("input still stalled after result taken");

    // The rounds register reads back no more than its seven bits.
    a_rounds_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[4:2] == REG_ROUNDS) |-> (prdata[DATA_W-1:ROUNDS_W] == '0))
        else $error("rounds register reads stray bits");

endmodule

bind tea_block_cipher tea_checker u_tea_checker (.*);
